/* src/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared codes and types of the priority task scheduler: command codes, the
// per-cell operation broadcast, cell status and the search token.
// ----------------------------------------------------------------------------
package pts_pkg;

  // widest task index over the supported task counts (up to 64)
  localparam int ID_W   = 6;
  localparam int PRIO_W = 5;

  // request function codes
  localparam logic [2:0] FN_READY   = 3'd0;
  localparam logic [2:0] FN_UNREADY = 3'd1;
  localparam logic [2:0] FN_DELAY   = 3'd2;
  localparam logic [2:0] FN_CANCEL  = 3'd3;
  localparam logic [2:0] FN_TICK    = 3'd4;
  localparam logic [2:0] FN_LOCK    = 3'd5;
  localparam logic [2:0] FN_UNLOCK  = 3'd6;
  localparam logic [2:0] FN_SCHED   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_LOCKED = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic [7:0] LOCK_LIMIT = 8'd255;

  // cell operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_READY  = 3'd1;
  localparam logic [2:0] OP_DEQ    = 3'd2;
  localparam logic [2:0] OP_DELAY  = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;
  localparam logic [2:0] OP_WAKE   = 3'd5;
  localparam logic [2:0] OP_SLICE  = 3'd6;

  typedef struct packed {
    logic [2:0]        op;
    logic [ID_W-1:0]   tgt;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   rank;      // new queue position of the target
    logic [ID_W-1:0]   ref_rank;  // position that leaves the queue
    logic              rot;       // slice expiry moves target to the tail
    logic [31:0]       ticks;
    logic [15:0]       slice_ld;
  } cell_cmd_t;

  typedef struct packed {
    logic              queued;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   rank;
    logic              delay_active;
    logic              delay_hit;
    logic              slice_hit;
  } cell_sts_t;

  typedef struct packed {
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } tok_t;

endpackage

/* src/pts_cell.sv */
// ----------------------------------------------------------------------------
// pts_cell
// One task slot: queue membership, priority, position in its priority queue,
// delay counter and time slice. Passes the head search token to its neighbor.
// ----------------------------------------------------------------------------
module pts_cell import pts_pkg::*; #(
  parameter int ID = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  tok_t      tok_in,
  output tok_t      tok_out,
  output cell_sts_t sts
);

  logic              queued;
  logic              active;
  logic [31:0]       dleft;
  logic [PRIO_W-1:0] prio;
  logic [ID_W-1:0]   rank;
  logic [15:0]       slice;
  logic              me;
  logic              behind;
  logic              take;

  assign me     = (cmd.tgt == ID_W'(ID));
  // queue neighbor behind the leaving position
  assign behind = queued && (prio == cmd.prio) && (rank > cmd.ref_rank);

  // head search: keep the best queue head seen so far
  assign take = queued && (rank == '0) && (!tok_in.found || prio < tok_in.prio);

  assign sts.queued       = queued;
  assign sts.prio         = prio;
  assign sts.rank         = rank;
  assign sts.delay_active = active;
  assign sts.delay_hit    = (dleft == 32'd1);
  assign sts.slice_hit    = (slice == 16'd1);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      queued  <= 1'b0;
      active  <= 1'b0;
      dleft   <= '0;
      tok_out <= '0;
    end else begin
      tok_out <= take ? '{found: 1'b1, prio: prio, id: ID_W'(ID)} : tok_in;
      case (cmd.op)
        OP_READY: if (me) queued <= 1'b1;
        OP_DEQ: if (me) queued <= 1'b0;
        OP_DELAY: if (me) begin
          dleft  <= (cmd.ticks == '0) ? 32'd1 : cmd.ticks;
          active <= 1'b1;
        end
        OP_CANCEL: if (me) active <= 1'b0;
        OP_WAKE: if (me && active) begin
          dleft <= dleft - 32'd1;
          if (dleft == 32'd1) begin
            active <= 1'b0;
            queued <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_READY: if (me) begin
        prio  <= cmd.prio;
        rank  <= cmd.rank;
        slice <= cmd.slice_ld;
      end
      OP_DEQ: if (!me && behind) rank <= rank - 1'b1;
      OP_WAKE: if (me && active && dleft == 32'd1 && !queued) begin
        rank  <= cmd.rank;
        slice <= cmd.slice_ld;
      end
      OP_SLICE: begin
        if (me) begin
          if (slice == 16'd1) begin
            slice <= cmd.slice_ld;
            if (cmd.rot) rank <= cmd.rank;
          end else begin
            slice <= slice - 16'd1;
          end
        end else if (cmd.rot && behind) begin
          rank <= rank - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/priority_task_scheduler.sv */
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Bitmap priority scheduler with per-priority FIFO ready queues, delays,
// round-robin time slices and a nesting lock.
// ----------------------------------------------------------------------------
// Usage: one request (func, task_id, task_prio, delay_ticks) is taken on the
// input channel when in_valid is high and in_stall low; each request gives
// exactly one result on the output channel, held while out_stall is high.
// slice_max is written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce. Each task
// is a cell in a chain; a head search token moves one cell per cycle, and a
// tick walks the delay counters one cell per cycle. An unlocked schedule and
// an unlock to zero run the head search; a tick walks the delay counters, then
// steps the running task's slice and runs the head search unless locked.
// One request is in work at a time; in_stall is high from accept until the
// result is loaded into the output register, which a stalled receiver holds.
// Reset empties all queues, cancels delays, clears the lock and running task
// and sets slice_max to 10.
// ----------------------------------------------------------------------------
module priority_task_scheduler import pts_pkg::*; #(
  parameter int TASK_COUNT = 16,
  parameter int PRIO_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [3:0]  task_id,
  input  logic [4:0]  task_prio,
  input  logic [31:0] delay_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        switch_request,
  output logic [3:0]  next_task,
  output logic [3:0]  current_task,
  output logic        current_valid,
  output logic [31:0] ready_bitmap,
  output logic [7:0]  lock_count,
  output logic [4:0]  woken_count,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int LW = $clog2(TASK_COUNT + 1);
  localparam int PW = (PRIO_COUNT > 1) ? $clog2(PRIO_COUNT) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_SLICE  = 3'd3;
  localparam logic [2:0] S_SEARCH = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]    state, state_next;
  logic [IW-1:0] step;
  logic [2:0]    req_func;
  logic [3:0]    req_tid;
  logic [4:0]    req_prio;
  logic [31:0]   req_ticks;
  logic [15:0]   slice_max;
  logic [LW-1:0] len [PRIO_COUNT];
  logic [7:0]    lock_depth;
  logic [IW-1:0] running_task;
  logic          running_valid;
  logic [4:0]    woken;
  logic [1:0]    res_status;
  logic          do_sched;

  cell_cmd_t     cmd;
  cell_sts_t     sts [TASK_COUNT];
  tok_t          tok [TASK_COUNT+1];
  cell_sts_t     s;
  logic [IW-1:0] sel;
  logic [PW-1:0] sp;
  logic          tid_ok;
  logic          prio_ok;
  logic [15:0]   slice_ld;
  logic [31:0]   bitmap;
  logic          out_free;
  logic          pick_sw;

  // cell chain
  assign tok[0] = '0;
  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    pts_cell #(.ID(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .sts     (sts[i])
    );
  end

  // selected cell and request checks
  always_comb begin
    case (state)
      S_WALK:  sel = step;
      S_SLICE: sel = running_task;
      default: sel = IW'(req_tid);
    endcase
  end
  assign s        = sts[sel];
  assign sp       = PW'(s.prio);
  assign tid_ok   = (32'(req_tid) < TASK_COUNT);
  assign prio_ok  = (32'(req_prio) < PRIO_COUNT);
  assign slice_ld = (slice_max == '0) ? 16'd1 : slice_max;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    bitmap = '0;
    for (int p = 0; p < PRIO_COUNT; p++) bitmap[p] = (len[p] != '0);
  end

  // cell operation broadcast
  always_comb begin
    cmd          = '0;
    cmd.tgt      = ID_W'(sel);
    cmd.ticks    = req_ticks;
    cmd.slice_ld = slice_ld;
    cmd.prio     = s.prio;
    cmd.ref_rank = s.rank;
    cmd.rank     = ID_W'(len[sp]);
    unique case (state)
      S_EXEC: begin
        case (req_func)
          FN_READY: if (tid_ok && prio_ok && !s.queued) begin
            cmd.op   = OP_READY;
            cmd.prio = req_prio;
            cmd.rank = ID_W'(len[PW'(req_prio)]);
          end
          FN_UNREADY: if (tid_ok && s.queued) cmd.op = OP_DEQ;
          FN_DELAY:   if (tid_ok) cmd.op = OP_DELAY;
          FN_CANCEL:  if (tid_ok) cmd.op = OP_CANCEL;
          default: ;
        endcase
      end
      S_WALK: cmd.op = OP_WAKE;
      S_SLICE: if (running_valid) begin
        cmd.op   = OP_SLICE;
        cmd.rot  = s.slice_hit && s.queued;
        cmd.rank = ID_W'(len[sp] - 1'b1);
      end
      S_IDLE, S_SEARCH, S_FIN: ;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        case (req_func)
          FN_TICK:   state_next = S_WALK;
          FN_UNLOCK: state_next = (lock_depth == 8'd1) ? S_SEARCH : S_FIN;
          FN_SCHED:  state_next = (lock_depth != '0) ? S_FIN : S_SEARCH;
          default:   state_next = S_FIN;
        endcase
      end
      S_WALK:   if (step == IW'(TASK_COUNT - 1)) state_next = S_SLICE;
      S_SLICE:  state_next = (lock_depth != '0) ? S_FIN : S_SEARCH;
      S_SEARCH: if (step == IW'(TASK_COUNT - 1)) state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign pick_sw = !running_valid || (running_task != IW'(tok[TASK_COUNT].id));

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      slice_max     <= 16'd10;
      lock_depth    <= '0;
      running_task  <= '0;
      running_valid <= 1'b0;
      out_valid     <= 1'b0;
      do_sched      <= 1'b0;
      for (int p = 0; p < PRIO_COUNT; p++) len[p] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) slice_max <= cfg_wdata;
      if (state == S_FIN && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      step <= (state_next == state && (state == S_WALK || state == S_SEARCH))
              ? step + 1'b1 : '0;
      unique case (state)
        S_IDLE: do_sched <= 1'b0;
        S_EXEC: begin
          case (req_func)
            FN_READY: if (tid_ok && prio_ok && !s.queued)
              len[PW'(req_prio)] <= len[PW'(req_prio)] + 1'b1;
            FN_UNREADY: if (tid_ok && s.queued) len[sp] <= len[sp] - 1'b1;
            FN_LOCK: if (lock_depth < LOCK_LIMIT) lock_depth <= lock_depth + 8'd1;
            FN_UNLOCK: if (lock_depth != '0) begin
              lock_depth <= lock_depth - 8'd1;
              if (lock_depth == 8'd1) do_sched <= 1'b1;
            end
            FN_SCHED: if (lock_depth == '0) do_sched <= 1'b1;
            default: ;
          endcase
        end
        S_WALK: if (s.delay_active && s.delay_hit && !s.queued)
          len[sp] <= len[sp] + 1'b1;
        S_SLICE: if (lock_depth == '0) do_sched <= 1'b1;
        S_FIN: if (out_free && do_sched && tok[TASK_COUNT].found) begin
          running_task  <= IW'(tok[TASK_COUNT].id);
          running_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request capture and per-request results
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_func  <= func;
      req_tid   <= task_id;
      req_prio  <= task_prio;
      req_ticks <= delay_ticks;
      woken     <= '0;
    end
    if (state == S_WALK && s.delay_active && s.delay_hit && woken != 5'd31)
      woken <= woken + 5'd1;
    if (state == S_EXEC)
      res_status <= ((req_func == FN_SCHED && lock_depth != '0) ? ST_LOCKED : ST_OK);
    if (state == S_SLICE)
      res_status <= (lock_depth != '0) ? ST_LOCKED : ST_OK;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      if (do_sched && tok[TASK_COUNT].found) begin
        switch_request <= pick_sw;
        next_task      <= 4'(tok[TASK_COUNT].id);
        current_task   <= 4'(tok[TASK_COUNT].id);
        current_valid  <= 1'b1;
        status         <= ST_OK;
      end else begin
        switch_request <= 1'b0;
        next_task      <= '0;
        current_task   <= 4'(running_task);
        current_valid  <= running_valid;
        status         <= do_sched ? ST_EMPTY : res_status;
      end
      ready_bitmap <= bitmap;
      lock_count   <= lock_depth;
      woken_count  <= (req_func == FN_TICK) ? woken : 5'd0;
    end
  end

endmodule

/* src/pts_checker.sv */
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the priority task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker import pts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        switch_request,
  input logic [3:0]  next_task,
  input logic [3:0]  current_task,
  input logic        current_valid,
  input logic [7:0]  lock_count,
  input logic [1:0]  status
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_task) && $stable(status))
    else $error("stalled result changed");

  // a switch names the running task
  assert property (@(posedge clk) disable iff (rst)
    out_valid && switch_request |-> current_valid && current_task == next_task)
    else $error("switch does not match running task");

  // suppressed scheduling only under a lock
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_LOCKED |-> lock_count != 8'd0)
    else $error("locked status without lock");

  // no switch without a pick
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> !switch_request)
    else $error("switch without ready task");

  // busy after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .switch_request (switch_request),
  .next_task      (next_task),
  .current_task   (current_task),
  .current_valid  (current_valid),
  .lock_count     (lock_count),
  .status         (status)
);

/* tb/priority_task_scheduler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_test
// Drives request sequences into the scheduler and checks every result field
// against a cycle-free behavioral predictor of the ready queues, delays,
// slices and lock. Runs several slice settings, bursty input, rotating
// output stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module priority_task_scheduler_test;
  import pts_pkg::*;

  localparam int NTASK = 16;
  localparam int NPRIO = 32;
  localparam int IDLE_LIMIT = 5000;
  localparam int CHUNK = 152;

  typedef struct packed {
    logic        sw;
    logic [3:0]  nxt;
    logic [3:0]  cur;
    logic        cv;
    logic [31:0] bmp;
    logic [7:0]  lk;
    logic [4:0]  wk;
    logic [1:0]  st;
  } sched_res_t;

  typedef struct {
    logic [2:0]  f;
    logic [3:0]  id;
    logic [4:0]  p;
    logic [31:0] tk;
    bit          typed;
    sched_res_t  res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = '0;
  logic [3:0]  task_id = '0;
  logic [4:0]  task_prio = '0;
  logic [31:0] delay_ticks = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        switch_request;
  logic [3:0]  next_task;
  logic [3:0]  current_task;
  logic        current_valid;
  logic [31:0] ready_bitmap;
  logic [7:0]  lock_count;
  logic [4:0]  woken_count;
  logic [1:0]  status;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  priority_task_scheduler u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .task_id(task_id), .task_prio(task_prio), .delay_ticks(delay_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .switch_request(switch_request), .next_task(next_task),
    .current_task(current_task), .current_valid(current_valid),
    .ready_bitmap(ready_bitmap), .lock_count(lock_count),
    .woken_count(woken_count), .status(status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [4:0]  task_prio_m [NTASK];
  logic [3:0]  link_m [NTASK];
  logic [3:0]  head_m [NPRIO];
  logic [3:0]  tail_m [NPRIO];
  logic [5:0]  qlen_m [NPRIO];
  logic [31:0] bitmap_m;
  logic [31:0] delay_m [NTASK];
  logic        delay_on_m [NTASK];
  logic [15:0] slice_m [NTASK];
  logic        in_queue_m [NTASK];
  bit          ever_ready [NTASK];
  logic [3:0]  run_task_m;
  logic        run_valid_m;
  logic [7:0]  lock_m;
  logic [15:0] slice_cfg;

  sched_res_t pending_results [$];
  int errors = 0;
  int checked = 0;
  int ticks_sent = 0;
  int wakes_seen = 0;
  int switches_seen = 0;
  int burst_left = 0;
  bit hold_go = 0;

  function automatic logic [15:0] slice_reload();
    return (slice_cfg == 16'd0) ? 16'd1 : slice_cfg;
  endfunction

  function automatic void queue_push(int t, int p);
    link_m[t] = t[3:0];
    if (qlen_m[p] == 0) head_m[p] = t[3:0];
    else link_m[tail_m[p]] = t[3:0];
    tail_m[p] = t[3:0];
    qlen_m[p]++;
    bitmap_m[p] = 1'b1;
    in_queue_m[t] = 1'b1;
  endfunction

  function automatic void queue_remove(int t, int p);
    int cur;
    int nx;
    if (qlen_m[p] == 0) begin
      in_queue_m[t] = 1'b0;
      return;
    end
    if (head_m[p] == t) begin
      head_m[p] = link_m[t];
    end else begin
      cur = head_m[p];
      for (int i = 0; i < qlen_m[p]; i++) begin
        nx = link_m[cur];
        if (nx == t) begin
          link_m[cur] = link_m[t];
          if (tail_m[p] == t) tail_m[p] = cur[3:0];
          break;
        end
        cur = nx;
      end
    end
    qlen_m[p]--;
    if (qlen_m[p] == 0) bitmap_m[p] = 1'b0;
    in_queue_m[t] = 1'b0;
  endfunction

  function automatic void make_ready_m(int t, int p);
    if (in_queue_m[t]) return;
    task_prio_m[t] = p[4:0];
    slice_m[t] = slice_reload();
    ever_ready[t] = 1;
    queue_push(t, p);
  endfunction

  function automatic logic [1:0] pick_task(inout sched_res_t r);
    if (lock_m > 0) return ST_LOCKED;
    for (int p = 0; p < NPRIO; p++) begin
      if (bitmap_m[p]) begin
        r.nxt = head_m[p];
        r.sw = !run_valid_m || run_task_m != head_m[p];
        run_task_m = head_m[p];
        run_valid_m = 1'b1;
        return ST_OK;
      end
    end
    return ST_EMPTY;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic sched_res_t sched_predict(logic [2:0] f, logic [3:0] t,
                                               logic [4:0] p, logic [31:0] tk);
    sched_res_t r;
    int c;
    int cp;
    r = '0;
    case (f)
      FN_READY: make_ready_m(t, p);
      FN_UNREADY: if (in_queue_m[t]) queue_remove(t, task_prio_m[t]);
      FN_DELAY: begin
        delay_m[t] = (tk == 0) ? 32'd1 : tk;
        delay_on_m[t] = 1'b1;
      end
      FN_CANCEL: delay_on_m[t] = 1'b0;
      FN_TICK: begin
        for (int i = 0; i < NTASK; i++) begin
          if (delay_on_m[i]) begin
            delay_m[i]--;
            if (delay_m[i] == 0) begin
              delay_on_m[i] = 1'b0;
              make_ready_m(i, task_prio_m[i]);
              if (r.wk < 31) r.wk++;
            end
          end
        end
        if (run_valid_m) begin
          c = run_task_m;
          slice_m[c]--;
          if (slice_m[c] == 0) begin
            if (in_queue_m[c]) begin
              cp = task_prio_m[c];
              queue_remove(c, cp);
              queue_push(c, cp);
            end
            slice_m[c] = slice_reload();
          end
        end
        r.st = pick_task(r);
      end
      FN_LOCK: if (lock_m < LOCK_LIMIT) lock_m++;
      FN_UNLOCK: begin
        if (lock_m > 0) begin
          lock_m--;
          if (lock_m == 0) r.st = pick_task(r);
        end
      end
      default: r.st = pick_task(r);
    endcase
    r.cur = run_task_m;
    r.cv = run_valid_m;
    r.bmp = bitmap_m;
    r.lk = lock_m;
    return r;
  endfunction

  // one request through the handshake, in bursts with random gaps
  task automatic issue(logic [2:0] f, logic [3:0] t, logic [4:0] p, logic [31:0] tk,
                       bit typed = 0, sched_res_t typed_res = '0);
    int gap;
    sched_res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 15);
    end
    in_valid <= 1'b1;
    func <= f;
    task_id <= t;
    task_prio <= p;
    delay_ticks <= tk;
    do @(posedge clk); while (in_stall);
    burst_left--;
    r = sched_predict(f, t, p, tk);
    if (f == FN_TICK) ticks_sent++;
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() > 0) @(posedge clk);
    // requests are serialized, so the block is idle once the last result left
    repeat (40) @(posedge clk);
  endtask

  task automatic write_slice(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_cfg = v;
  endtask

  task automatic random_request();
    int r;
    logic [3:0] t;
    logic [4:0] p;
    logic [31:0] tk;
    r = $urandom_range(0, 99);
    t = 4'($urandom_range(0, NTASK - 1));
    p = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
    tk = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 6));
    if (r < 25) issue(FN_READY, t, p, tk);
    else if (r < 35) issue(FN_UNREADY, t, p, tk);
    else if (r < 47) begin
      // a wake of a never-readied task would use an unwritten priority
      if (ever_ready[t]) issue(FN_DELAY, t, p, tk);
      else issue(FN_READY, t, p, tk);
    end
    else if (r < 52) issue(FN_CANCEL, t, p, tk);
    else if (r < 77) issue(FN_TICK, t, p, tk);
    else if (r < 83) issue(FN_LOCK, t, p, tk);
    else if (r < 91) issue(FN_UNLOCK, t, p, tk);
    else issue(FN_SCHED, t, p, tk);
  endtask

  task automatic flag_mismatch(string field, longint got, longint want);
    if (errors < 40)
      $display("mismatch #%0d on %s: got 0x%0h expected 0x%0h", checked, field, got, want);
    errors++;
  endtask

  // result checking and receiver stall pattern
  int rx_cycle = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    sched_res_t e;
    int mode;
    rx_cycle++;
    if (!rst && out_valid && !out_stall) begin
      checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (switch_request !== e.sw) flag_mismatch("switch_request", switch_request, e.sw);
        if (next_task !== e.nxt) flag_mismatch("next_task", next_task, e.nxt);
        if (current_task !== e.cur) flag_mismatch("current_task", current_task, e.cur);
        if (current_valid !== e.cv) flag_mismatch("current_valid", current_valid, e.cv);
        if (ready_bitmap !== e.bmp) flag_mismatch("ready_bitmap", ready_bitmap, e.bmp);
        if (lock_count !== e.lk) flag_mismatch("lock_count", lock_count, e.lk);
        if (woken_count !== e.wk) flag_mismatch("woken_count", woken_count, e.wk);
        if (status !== e.st) flag_mismatch("status", status, e.st);
        wakes_seen += e.wk;
        switches_seen += e.sw;
      end
    end
    if (hold_go) begin
      hold_go = 0;
      hold_left = 300;
    end
    mode = (rx_cycle / 97) % 4;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (mode == 0) out_stall <= 1'b0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 9) < 3);
    else if (mode == 2) out_stall <= ($urandom_range(0, 9) < 7);
    else out_stall <= rx_cycle[1];
  end

  // watchdog on cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  dir_row_t dir_tab [$];
  sched_res_t empty_res;

  initial begin
    logic [15:0] slice_plan [5];
    slice_cfg = 16'd10;
    bitmap_m = '0;
    run_task_m = '0;
    run_valid_m = 1'b0;
    lock_m = '0;
    for (int i = 0; i < NTASK; i++) begin
      task_prio_m[i] = '0;
      link_m[i] = '0;
      delay_m[i] = '0;
      delay_on_m[i] = 1'b0;
      slice_m[i] = '0;
      in_queue_m[i] = 1'b0;
      ever_ready[i] = 0;
    end
    for (int p = 0; p < NPRIO; p++) begin
      head_m[p] = '0;
      tail_m[p] = '0;
      qlen_m[p] = '0;
    end

    // scheduling with nothing ready right after reset
    empty_res = '0;
    empty_res.st = ST_EMPTY;
    dir_tab.push_back('{FN_SCHED, 4'd0, 5'd0, 32'd0, 1'b1, empty_res});
    dir_tab.push_back('{FN_TICK, 4'd3, 5'd7, 32'd0, 1'b1, empty_res});
    dir_tab.push_back('{FN_READY, 4'd15, 5'd31, 32'hFFFF_FFFF, 1'b0, '0});
    dir_tab.push_back('{FN_READY, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_READY, 4'd0, 5'd5, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_READY, 4'd1, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_READY, 4'd2, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_SCHED, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_SCHED, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_UNREADY, 4'd1, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_UNREADY, 4'd9, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_DELAY, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_DELAY, 4'd15, 5'd0, 32'hFFFF_FFFF, 1'b0, '0});
    dir_tab.push_back('{FN_DELAY, 4'd1, 5'd0, 32'd9, 1'b0, '0});
    dir_tab.push_back('{FN_DELAY, 4'd1, 5'd0, 32'd2, 1'b0, '0});
    dir_tab.push_back('{FN_TICK, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_TICK, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_CANCEL, 4'd15, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_CANCEL, 4'd7, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_LOCK, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_SCHED, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_TICK, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0, '0});
    dir_tab.push_back('{FN_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      issue(dir_tab[i].f, dir_tab[i].id, dir_tab[i].p, dir_tab[i].tk,
            dir_tab[i].typed, dir_tab[i].res);

    slice_plan = '{16'd1, 16'd65535, 16'd0, 16'd2, 16'($urandom_range(3, 8))};
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_idle();
      write_slice(slice_plan[ph]);
      for (int n = 0; n < CHUNK; n++) begin
        if (ph == 0 && n == CHUNK / 2) hold_go = 1;
        // lock nesting up to saturation and back down
        if (ph == 2 && n == 10) begin
          repeat (258) issue(FN_LOCK, 4'($urandom), 5'($urandom), $urandom());
          repeat (257) issue(FN_UNLOCK, 4'($urandom), 5'($urandom), $urandom());
        end
        random_request();
      end
    end

    drain_and_idle();
    $display("results checked: %0d, ticks: %0d, delay wakes: %0d, task switches: %0d",
             checked, ticks_sent, wakes_seen, switches_seen);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
src/pts_pkg.sv
src/pts_cell.sv
src/priority_task_scheduler.sv
src/pts_checker.sv
tb/priority_task_scheduler_test.sv
